@@ src/baro_temp_press_compensate_macros.svh @@
`ifndef BARO_TEMP_PRESS_COMPENSATE_MACROS_SVH
`define BARO_TEMP_PRESS_COMPENSATE_MACROS_SVH

// Check that holds in the same cycle as its trigger.
`define BTPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that holds in the cycle after its trigger.
`define BTPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/btpc_pkg.sv @@
`default_nettype none

package btpc_pkg;

  // raw conversion code that marks a skipped reading
  localparam logic [19:0] SKIP_CODE  = 20'd524288;
  localparam logic [63:0] TF_OFFSET  = 64'd128000;
  localparam logic [20:0] P_BASE     = 21'd1048576;
  localparam logic [63:0] P_SCALE    = 64'd3125;
  localparam logic [27:0] TC_ROUND   = 28'd128;
  localparam logic [27:0] TC_TRUNC   = 28'd255;

  // input queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // divider
  localparam int DIV_BITS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

  typedef enum logic [1:0] {
    CFG_TEMP_TRIM  = 2'd0,
    CFG_PRESS_LOW  = 2'd1,
    CFG_PRESS_HIGH = 2'd2,
    CFG_PRESS_P9   = 2'd3
  } btpc_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TSKIP = 2'd1,
    ST_PSKIP = 2'd2,
    ST_DIVZ  = 2'd3
  } btpc_status_t;

  typedef struct packed {
    logic [19:0] at;
    logic [19:0] ap;
    logic        skip_t;
    logic        skip_p;
  } btpc_item_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] plo;
    logic [63:0] phi;
    logic [15:0] p9;
  } btpc_trim_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

@@ src/baro_temp_press_compensate.sv @@
// Barometric temperature and pressure compensation.
// Input channel: in_valid / in_stall with the raw 20-bit temperature and
// pressure conversions. A word is taken when in_valid is high and in_stall low;
// a two-word queue keeps taking words while the back end works.
// Output channel: out_valid / out_stall with centi-degrees, Q24.8 pressure,
// fine temperature and status. The result sits in an output register until
// taken; while out_stall is high the word holds and the back end waits.
// One item at a time in the back end, which shares one 32x32 multiplier
// and a radix-2 divider: 13 products for a full item, only the three
// temperature products when the pressure is skipped, none when the
// temperature is skipped. Trimming words are written on cfg_we with
// cfg_index/cfg_data; the user must do so only while idle (not enforced).
// Reset (rst_n low, synchronous) clears the trims, queue and output valid.
`default_nettype none
`include "baro_temp_press_compensate_macros.svh"

module baro_temp_press_compensate import btpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        in_adc_temperature,
  input  logic [19:0]        in_adc_pressure,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_temperature_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic signed [31:0] out_fine_temperature,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  btpc_trim_t trim_r;
  btpc_item_t item;
  logic       item_valid, item_pop;

  // trimming registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP_TRIM:  trim_r.temp <= cfg_data[47:0];
        CFG_PRESS_LOW:  trim_r.plo  <= cfg_data;
        CFG_PRESS_HIGH: trim_r.phi  <= cfg_data;
        CFG_PRESS_P9:   trim_r.p9   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  btpc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_adc_temperature(in_adc_temperature), .in_adc_pressure(in_adc_pressure),
    .item_valid(item_valid), .item(item), .item_pop(item_pop)
  );

  btpc_back u_back (
    .clk(clk), .rst_n(rst_n), .trim(trim_r),
    .item_valid(item_valid), .item(item), .item_pop(item_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_temperature_centi(out_temperature_centi),
    .out_pressure_q24_8(out_pressure_q24_8),
    .out_fine_temperature(out_fine_temperature),
    .out_status(out_status)
  );

  // skipped temperature clears every value field
  `BTPC_ASSERT_IMP(a_tskip_zero, out_valid && (out_status == ST_TSKIP), (out_fine_temperature == 32'sd0) && (out_pressure_q24_8 == 32'd0) && (out_temperature_centi == 24'sd0), "skipped temperature gave nonzero fields")
  // any error status carries zero pressure
  `BTPC_ASSERT_IMP(a_err_press, out_valid && (out_status != ST_OK), out_pressure_q24_8 == 32'd0, "error status with nonzero pressure")
  // fine temperature stays inside 25 signed bits
  `BTPC_ASSERT_IMP(a_fine_range, out_valid, (out_fine_temperature < 32'sd16777216) && (out_fine_temperature > -32'sd16777216), "fine temperature out of range")
  // a taken word is visible to the back end next cycle
  `BTPC_ASSERT_NXT(a_queue_fill, in_valid && !in_stall, item_valid, "queue empty after push")

endmodule

`default_nettype wire

@@ src/btpc_mul.sv @@
`default_nettype none

// 64x64 product, low 64 bits, from three 32x32 partial products
module btpc_mul import btpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [63:0] a_r, b_r, prod_r, prod_nxt, acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [31:0] op_x, op_y;

  // partial product select
  always_comb begin
    case (cnt_r)
      2'd0: begin op_x = a_r[31:0];  op_y = b_r[31:0];  end
      2'd1: begin op_x = a_r[31:0];  op_y = b_r[63:32]; end
      2'd2: begin op_x = a_r[63:32]; op_y = b_r[31:0];  end
      default: begin op_x = '0; op_y = '0; end
    endcase
    prod_nxt = {32'b0, op_x} * {32'b0, op_y};
  end

  // accumulate registered products
  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 2'd1;
      case (cnt_r)
        2'd1: acc_nxt = prod_r;
        2'd2: acc_nxt = acc_r + {prod_r[31:0], 32'b0};
        2'd3: begin
          acc_nxt  = acc_r + {prod_r[31:0], 32'b0};
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

`default_nettype wire

@@ src/btpc_div.sv @@
`default_nettype none

// signed 64-bit divide, truncating, one quotient bit per cycle
module btpc_div import btpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] q_r, q_nxt, rem_r, rem_nxt, d_r, d_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, fix_r, fix_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [64:0] sh, diff;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    sh       = {rem_r, q_r[63]};
    diff     = sh - {1'b0, d_r};
    if (start) begin
      // work on magnitudes, sign fixed at the end
      neg_nxt  = num[63] ^ den[63];
      q_nxt    = num[63] ? (64'd0 - num) : num;
      d_nxt    = den[63] ? (64'd0 - den) : den;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIV_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restoring step
      if (!diff[64]) begin
        rem_nxt = diff[63:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh[63:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      q_nxt    = neg_r ? (64'd0 - q_r) : q_r;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

`default_nettype wire

@@ src/btpc_front.sv @@
`default_nettype none

// accepts readings, flags skipped codes, queues them for the back end
module btpc_front import btpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_adc_temperature,
  input  logic [19:0] in_adc_pressure,
  output logic        item_valid,
  output btpc_item_t  item,
  input  logic        item_pop
);

  btpc_item_t              q_r [QDEPTH];
  btpc_item_t              new_item;
  logic [QPTR_W-1:0]       wr_r, rd_r;
  logic [QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                    push;

  // classify the incoming word
  always_comb begin
    new_item.at     = in_adc_temperature;
    new_item.ap     = in_adc_pressure;
    new_item.skip_t = (in_adc_temperature == SKIP_CODE);
    new_item.skip_p = (in_adc_pressure == SKIP_CODE);
  end

  assign in_stall   = (cnt_r == QCNT_W'(QDEPTH));
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !item_pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push && item_pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (item_pop) rd_r <= rd_r + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= new_item;
  end

endmodule

`default_nettype wire

@@ src/btpc_back.sv @@
`default_nettype none

// compensation sequencer over a shared multiplier and divider
module btpc_back import btpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  btpc_trim_t         trim,
  input  logic               item_valid,
  input  btpc_item_t         item,
  output logic               item_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_temperature_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic signed [31:0] out_fine_temperature,
  output logic [1:0]         out_status
);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001, S_T0  = 19'h00002, S_T1  = 19'h00004, S_T2  = 19'h00008,
    S_TC   = 19'h00010, S_M1  = 19'h00020, S_M2  = 19'h00040, S_M3  = 19'h00080,
    S_M4   = 19'h00100, S_M5  = 19'h00200, S_M6  = 19'h00400, S_M7  = 19'h00800,
    S_DV   = 19'h01000, S_M8  = 19'h02000, S_M9  = 19'h04000, S_M10 = 19'h08000,
    S_F1   = 19'h10000, S_F2  = 19'h20000, S_DN  = 19'h40000
  } btpc_state_t;

  localparam logic [18:0] MUL_STATES = S_T0 | S_T1 | S_T2 | S_M1 | S_M2 | S_M3 | S_M4 |
                                       S_M5 | S_M6 | S_M7 | S_M8 | S_M9 | S_M10;

  btpc_state_t  st_r, st_nxt;
  btpc_item_t   it_r, it_nxt;
  btpc_status_t stat_r, stat_nxt, ostat_r;
  logic         go_r, go_nxt;
  logic [63:0]  a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, x_r, x_nxt;
  logic [63:0]  sq_r, sq_nxt, n_r, n_nxt, q_r, q_nxt;
  logic [31:0]  tf_r, tf_nxt, press_r, press_nxt;
  logic [27:0]  cx_r, cx_nxt;
  logic         ov_r, ov_nxt;
  logic signed [23:0] ocenti_r;
  logic [31:0]  opress_r, ofine_r;
  logic         load_out;

  logic         mul_start, mul_done, div_start, div_done, is_mul, step, dstep;
  logic [63:0]  mul_a, mul_b, mul_p, div_q;
  logic signed [63:0] ps, qs, cs;
  logic [63:0]  t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic [20:0]  base_diff;
  logic [63:0]  tf_sum, den_v, tfx;
  logic [27:0]  tf28;
  logic signed [27:0] cxs, adj, qd;

  btpc_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  btpc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(n_r), .den(a_r),
    .done(div_done), .quo(div_q)
  );

  // trimming coefficients
  assign t2 = sx16(trim.temp[31:16]);
  assign t3 = sx16(trim.temp[47:32]);
  assign p1 = {48'b0, trim.plo[15:0]};
  assign p2 = sx16(trim.plo[31:16]);
  assign p3 = sx16(trim.plo[47:32]);
  assign p4 = sx16(trim.plo[63:48]);
  assign p5 = sx16(trim.phi[15:0]);
  assign p6 = sx16(trim.phi[31:16]);
  assign p7 = sx16(trim.phi[47:32]);
  assign p8 = sx16(trim.phi[63:48]);
  assign p9 = sx16(trim.p9);

  assign ps = mul_p;
  assign qs = q_r;
  assign cs = c_r;

  // raw temperature offsets
  assign d1 = $signed({1'b0, it_r.at[19:3]}) - $signed({1'b0, trim.temp[15:0], 1'b0});
  assign d2 = $signed({1'b0, it_r.at[19:4]}) - $signed({1'b0, trim.temp[15:0]});
  assign base_diff = P_BASE - {1'b0, it_r.ap};
  assign tf_sum = c_r + 64'(ps >>> 14);
  assign den_v  = 64'(ps >>> 33);
  assign tfx    = {{32{tf_r[31]}}, tf_r};
  assign tf28   = tf_r[27:0];

  // unit launch and completion
  assign is_mul    = |(st_r & MUL_STATES);
  assign mul_start = is_mul && !go_r;
  assign step      = is_mul && go_r && mul_done;
  assign div_start = (st_r == S_DV) && !go_r;
  assign dstep     = (st_r == S_DV) && go_r && div_done;

  // centi value: truncate toward zero; magnitude stays well inside 24 bits
  assign cxs = cx_r;
  assign adj = cxs[27] ? (cxs + $signed(TC_TRUNC)) : cxs;
  assign qd  = adj >>> 8;

  always_comb begin
    case (st_r)
      S_T0:  begin mul_a = {{46{d1[17]}}, d1}; mul_b = t2; end
      S_T1:  begin mul_a = {{47{d2[16]}}, d2}; mul_b = {{47{d2[16]}}, d2}; end
      S_T2:  begin mul_a = sq_r; mul_b = t3; end
      S_M1:  begin mul_a = x_r;  mul_b = x_r; end
      S_M2:  begin mul_a = sq_r; mul_b = p6; end
      S_M3:  begin mul_a = x_r;  mul_b = p5; end
      S_M4:  begin mul_a = sq_r; mul_b = p3; end
      S_M5:  begin mul_a = x_r;  mul_b = p2; end
      S_M6:  begin mul_a = a_r + (64'd1 << 47); mul_b = p1; end
      S_M7:  begin mul_a = ({43'b0, base_diff} << 31) - b_r; mul_b = P_SCALE; end
      S_M8:  begin mul_a = p9;   mul_b = 64'(qs >>> 13); end
      S_M9:  begin mul_a = c_r;  mul_b = 64'(qs >>> 13); end
      S_M10: begin mul_a = p8;   mul_b = q_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    it_nxt    = it_r;
    stat_nxt  = stat_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    x_nxt     = x_r;
    sq_nxt    = sq_r;
    n_nxt     = n_r;
    q_nxt     = q_r;
    tf_nxt    = tf_r;
    press_nxt = press_r;
    cx_nxt    = cx_r;
    item_pop  = 1'b0;
    load_out  = 1'b0;
    go_nxt    = go_r;
    if (mul_start || div_start) go_nxt = 1'b1;
    else if (step || dstep) go_nxt = 1'b0;
    ov_nxt = ov_r && out_stall;

    unique case (st_r)
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          it_nxt   = item;
          if (item.skip_t) begin
            stat_nxt  = ST_TSKIP;
            tf_nxt    = '0;
            cx_nxt    = '0;
            press_nxt = '0;
            st_nxt    = S_DN;
          end else begin
            st_nxt = S_T0;
          end
        end
      end
      S_T0: if (step) begin c_nxt = 64'(ps >>> 11); st_nxt = S_T1; end
      S_T1: if (step) begin sq_nxt = 64'(ps >>> 12); st_nxt = S_T2; end
      S_T2: if (step) begin tf_nxt = tf_sum[31:0]; st_nxt = S_TC; end
      S_TC: begin
        cx_nxt = (tf28 << 2) + tf28 + TC_ROUND;
        x_nxt  = tfx - TF_OFFSET;
        if (it_r.skip_p) begin
          stat_nxt  = ST_PSKIP;
          press_nxt = '0;
          st_nxt    = S_DN;
        end else begin
          st_nxt = S_M1;
        end
      end
      S_M1: if (step) begin sq_nxt = mul_p; st_nxt = S_M2; end
      S_M2: if (step) begin b_nxt = mul_p + (p4 << 35); st_nxt = S_M3; end
      S_M3: if (step) begin b_nxt = b_r + (mul_p << 17); st_nxt = S_M4; end
      S_M4: if (step) begin a_nxt = 64'(ps >>> 8); st_nxt = S_M5; end
      S_M5: if (step) begin a_nxt = a_r + (mul_p << 12); st_nxt = S_M6; end
      S_M6: begin
        if (step) begin
          a_nxt = den_v;
          if (den_v == '0) begin
            stat_nxt  = ST_DIVZ;
            press_nxt = '0;
            st_nxt    = S_DN;
          end else begin
            st_nxt = S_M7;
          end
        end
      end
      S_M7:  if (step) begin n_nxt = mul_p; st_nxt = S_DV; end
      S_DV:  if (dstep) begin q_nxt = div_q; st_nxt = S_M8; end
      S_M8:  if (step) begin c_nxt = mul_p; st_nxt = S_M9; end
      S_M9:  if (step) begin c_nxt = 64'(ps >>> 25); st_nxt = S_M10; end
      S_M10: if (step) begin c_nxt = c_r + 64'(ps >>> 19); st_nxt = S_F1; end
      S_F1:  begin c_nxt = q_r + c_r; st_nxt = S_F2; end
      S_F2: begin
        press_nxt = 32'(64'(cs >>> 8) + (p7 << 4));
        stat_nxt  = ST_OK;
        st_nxt    = S_DN;
      end
      S_DN: begin
        // hand the result to the output register once it is free
        if (!ov_r || !out_stall) begin
          load_out = 1'b1;
          ov_nxt   = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      go_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      go_r <= go_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r    <= it_nxt;
    stat_r  <= stat_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    x_r     <= x_nxt;
    sq_r    <= sq_nxt;
    n_r     <= n_nxt;
    q_r     <= q_nxt;
    tf_r    <= tf_nxt;
    press_r <= press_nxt;
    cx_r    <= cx_nxt;
    if (load_out) begin
      ocenti_r <= qd[23:0];
      opress_r <= press_r;
      ofine_r  <= tf_r;
      ostat_r  <= stat_r;
    end
  end

  assign out_valid             = ov_r;
  assign out_temperature_centi = ocenti_r;
  assign out_pressure_q24_8    = opress_r;
  assign out_fine_temperature  = ofine_r;
  assign out_status            = ostat_r;

endmodule

`default_nettype wire
